>>> rtl/core/six_step_commutation_sequencer_unit_macros.svh
// assertion macros shared by the sequencer modules
`ifndef SIX_STEP_COMMUTATION_SEQUENCER_UNIT_MACROS_SVH
`define SIX_STEP_COMMUTATION_SEQUENCER_UNIT_MACROS_SVH

// property checked on every clock, masked during reset
`define SSCS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// condition must be followed by a result on the next clock
`define SSCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/sscs_pkg.sv
// types, constants and sector table of the commutation sequencer
`default_nettype none
package sscs_pkg;

    localparam int THR_W       = 11;
    localparam int ERR_W       = 16;
    localparam int SECTOR_W    = 3;
    localparam int MODE_W      = 2;
    localparam int SCALE_SHIFT = 6;

    localparam logic [THR_W-1:0] PLAUS_RESET = 11'h3F8;
    localparam logic [ERR_W-1:0] ERR_MAX     = 16'h7FFF;
    localparam logic [ERR_W-1:0] ERR_OFFSET  = 16'h0040;

    localparam logic FUNC_ADVANCE = 1'b0;
    localparam logic FUNC_ALIGN   = 1'b1;

    localparam logic [SECTOR_W-1:0] NUM_SECTORS    = 3'd6;
    localparam logic [SECTOR_W-1:0] SECTOR_RISING  = 3'd0;
    localparam logic [SECTOR_W-1:0] SECTOR_ONE     = 3'd1;
    localparam logic [SECTOR_W-1:0] SECTOR_SUPPLY  = 3'd2;
    localparam logic [SECTOR_W-1:0] SECTOR_FALLING = 3'd3;
    localparam logic [SECTOR_W-1:0] SECTOR_FOUR    = 3'd4;
    localparam logic [SECTOR_W-1:0] SECTOR_ERROR   = 3'd5;

    localparam logic [MODE_W-1:0] MODE_LOW   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PWM   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FLOAT = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SAT,
        ST_PUBLISH
    } t_state;

    typedef struct packed {
        logic exec;
        logic div_step;
        logic err_load;
        logic publish;
    } t_dp_cmd;

    typedef struct packed {
        logic need_div;
        logic out_free;
    } t_dp_sts;

    typedef struct packed {
        logic [MODE_W-1:0] a;
        logic [MODE_W-1:0] b;
        logic [MODE_W-1:0] c;
    } t_drive;

    // phase drive modes per sector
    function automatic t_drive sector_drive(input logic [SECTOR_W-1:0] s);
        t_drive d;
        case (s)
            SECTOR_RISING:  d = '{a: MODE_PWM,   b: MODE_LOW,   c: MODE_FLOAT};
            SECTOR_ONE:     d = '{a: MODE_PWM,   b: MODE_FLOAT, c: MODE_LOW};
            SECTOR_SUPPLY:  d = '{a: MODE_FLOAT, b: MODE_PWM,   c: MODE_LOW};
            SECTOR_FALLING: d = '{a: MODE_LOW,   b: MODE_PWM,   c: MODE_FLOAT};
            SECTOR_FOUR:    d = '{a: MODE_LOW,   b: MODE_FLOAT, c: MODE_PWM};
            SECTOR_ERROR:   d = '{a: MODE_FLOAT, b: MODE_LOW,   c: MODE_PWM};
            default:        d = '{a: MODE_PWM,   b: MODE_LOW,   c: MODE_FLOAT};
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/sscs_cmd_if.sv
// command channel: function, run flag and adc sample
`default_nettype none
interface sscs_cmd_if #(
    parameter int ADC_BITS = 10
);
    logic                valid;
    logic                ready;
    logic                func;
    logic                motor_running;
    logic [ADC_BITS-1:0] adc_sample;

    modport source (output valid, output func, output motor_running,
                    output adc_sample, input ready);
    modport sink   (input valid, input func, input motor_running,
                    input adc_sample, output ready);
endinterface
`default_nettype wire

>>> rtl/core/sscs_res_if.sv
// result channel: sector, drive modes and measurements
`default_nettype none
interface sscs_res_if
    import sscs_pkg::*;
#(
    parameter int ADC_BITS = 10
);
    logic                valid;
    logic                ready;
    logic [SECTOR_W-1:0] sector;
    logic [MODE_W-1:0]   phase_a_mode;
    logic [MODE_W-1:0]   phase_b_mode;
    logic [MODE_W-1:0]   phase_c_mode;
    logic                drive_updated;
    logic [ADC_BITS-1:0] bemf_rising;
    logic [ADC_BITS-1:0] bemf_falling;
    logic [ADC_BITS-1:0] supply_voltage;
    logic signed [ERR_W-1:0] timing_error;
    logic                error_plausible;

    modport source (output valid, output sector, output phase_a_mode,
                    output phase_b_mode, output phase_c_mode, output drive_updated,
                    output bemf_rising, output bemf_falling, output supply_voltage,
                    output timing_error, output error_plausible, input ready);
    modport sink   (input valid, input sector, input phase_a_mode,
                    input phase_b_mode, input phase_c_mode, input drive_updated,
                    input bemf_rising, input bemf_falling, input supply_voltage,
                    input timing_error, input error_plausible, output ready);
endinterface
`default_nettype wire

>>> rtl/core/sscs_cfg_if.sv
// configuration write channel for the plausibility threshold
`default_nettype none
interface sscs_cfg_if
    import sscs_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [THR_W-1:0] plausible_threshold;

    modport source (output valid, output plausible_threshold, input ready);
    modport sink   (input valid, input plausible_threshold, output ready);
endinterface
`default_nettype wire

>>> rtl/core/sscs_ctrl.sv
// controller state machine of the commutation sequencer
`default_nettype none
`include "six_step_commutation_sequencer_unit_macros.svh"
module sscs_ctrl
    import sscs_pkg::*;
#(
    parameter int ADC_BITS = 10
) (
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_cmd_valid,
    output logic    o_cmd_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);
    localparam int DIV_W = ADC_BITS + SCALE_SHIFT;
    localparam int CNT_W = $clog2(DIV_W);

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                n_cnt = CNT_W'(DIV_W - 1);
                if (i_cmd_valid) begin
                    n_state = i_sts.need_div ? ST_DIV : ST_PUBLISH;
                end
            end
            ST_DIV: begin
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_SAT;
                end
            end
            ST_SAT: begin
                n_state = ST_PUBLISH;
            end
            ST_PUBLISH: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_cmd_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_cmd_ready = 1'b1;
                o_cmd.exec  = i_cmd_valid;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            ST_SAT: begin
                o_cmd.err_load = 1'b1;
            end
            ST_PUBLISH: begin
                o_cmd.publish = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    `SSCS_ASSERT_NEXT(a_accept_leaves_idle, o_cmd_ready && i_cmd_valid, r_state != ST_IDLE, "transaction accepted but controller stayed idle")
    `SSCS_ASSERT_NEXT(a_div_ends_in_sat, r_state == ST_DIV && r_cnt == '0, r_state == ST_SAT, "divider did not finish after its last step")
    `SSCS_ASSERT_NEXT(a_sat_to_publish, r_state == ST_SAT, r_state == ST_PUBLISH && o_cmd_ready == 1'b0, "saturation not followed by publish")

endmodule
`default_nettype wire

>>> rtl/core/sscs_dp.sv
// datapath: sector state, averages, divider and result register
`default_nettype none
`include "six_step_commutation_sequencer_unit_macros.svh"
module sscs_dp
    import sscs_pkg::*;
#(
    parameter int ADC_BITS = 10
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_func,
    input  wire                i_motor_running,
    input  wire [ADC_BITS-1:0] i_adc_sample,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    sscs_cfg_if.sink           cfg,
    sscs_res_if.source         res
);
    localparam int DIV_W = ADC_BITS + SCALE_SHIFT;
    localparam int SUM_W = (ADC_BITS + 1 > THR_W) ? ADC_BITS + 1 : THR_W;

    logic [SECTOR_W-1:0] r_sector,  n_sector;
    t_drive              r_drive,   n_drive;
    logic [ADC_BITS-1:0] r_rising,  n_rising;
    logic [ADC_BITS-1:0] r_falling, n_falling;
    logic [ADC_BITS-1:0] r_supply,  n_supply;
    logic                r_updated, n_updated;
    logic [ERR_W-1:0]    r_error;
    logic [THR_W-1:0]    r_threshold;

    logic [DIV_W-1:0]    r_quo;
    logic [ADC_BITS-1:0] r_rem;
    logic [ADC_BITS-1:0] r_div;

    logic                r_out_valid;
    logic [SECTOR_W-1:0] r_out_sector;
    t_drive              r_out_drive;
    logic                r_out_updated;
    logic [ADC_BITS-1:0] r_out_rising;
    logic [ADC_BITS-1:0] r_out_falling;
    logic [ADC_BITS-1:0] r_out_supply;
    logic [ERR_W-1:0]    r_out_error;
    logic                r_out_plausible;

    logic [SECTOR_W-1:0] w_next_sector;
    logic [ADC_BITS:0]   w_rise_sum;
    logic [ADC_BITS:0]   w_fall_sum;
    logic [ADC_BITS:0]   w_rem_sh;
    logic [ADC_BITS:0]   w_rem_diff;
    logic                w_ge;
    logic [31:0]         w_quo_ext;
    logic [31:0]         w_err_diff;
    logic [ERR_W-1:0]    w_err_sat;
    logic [SUM_W-1:0]    w_bemf_sum;
    logic                w_plausible;

    assign w_next_sector = (r_sector == SECTOR_ERROR) ? SECTOR_RISING
                                                      : r_sector + 3'd1;
    assign w_rise_sum = {1'b0, r_rising} + {1'b0, i_adc_sample};
    assign w_fall_sum = {1'b0, r_falling} + {1'b0, i_adc_sample};

    assign o_sts.need_div = (i_func == FUNC_ADVANCE) && i_motor_running
                            && (w_next_sector == SECTOR_ERROR);
    assign o_sts.out_free = !r_out_valid || res.ready;

    // sector actions
    always_comb begin
        n_sector  = r_sector;
        n_drive   = r_drive;
        n_rising  = r_rising;
        n_falling = r_falling;
        n_supply  = r_supply;
        n_updated = r_updated;
        if (i_cmd.exec) begin
            if (i_func == FUNC_ALIGN) begin
                n_sector  = SECTOR_RISING;
                n_drive   = sector_drive(SECTOR_RISING);
                n_rising  = w_rise_sum[ADC_BITS:1];
                n_updated = 1'b1;
            end else begin
                n_sector = w_next_sector;
                if (i_motor_running) begin
                    n_drive   = sector_drive(w_next_sector);
                    n_updated = 1'b1;
                    case (w_next_sector)
                        SECTOR_RISING:  n_rising  = w_rise_sum[ADC_BITS:1];
                        SECTOR_SUPPLY:  n_supply  = i_adc_sample;
                        SECTOR_FALLING: n_falling = w_fall_sum[ADC_BITS:1];
                        default:        n_updated = 1'b1;
                    endcase
                end else begin
                    n_rising  = '0;
                    n_falling = '0;
                    n_supply  = '0;
                    n_updated = 1'b0;
                end
            end
        end
    end

    // restoring divider step, zero divisor yields an all-ones quotient
    assign w_rem_sh   = {r_rem, r_quo[DIV_W-1]};
    assign w_rem_diff = w_rem_sh - {1'b0, r_div};
    assign w_ge       = w_rem_sh >= {1'b0, r_div};

    assign w_quo_ext  = 32'(r_quo);
    assign w_err_diff = w_quo_ext - 32'(ERR_OFFSET);
    assign w_err_sat  = (w_quo_ext > (32'(ERR_MAX) + 32'(ERR_OFFSET)))
                        ? ERR_MAX : w_err_diff[ERR_W-1:0];

    assign w_bemf_sum  = SUM_W'(r_rising) + SUM_W'(r_falling);
    assign w_plausible = w_bemf_sum > SUM_W'(r_threshold);

    assign cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sector    <= SECTOR_RISING;
            r_drive     <= '{a: MODE_FLOAT, b: MODE_FLOAT, c: MODE_FLOAT};
            r_rising    <= '0;
            r_falling   <= '0;
            r_supply    <= '0;
            r_updated   <= 1'b0;
            r_error     <= '0;
            r_threshold <= PLAUS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_sector  <= n_sector;
            r_drive   <= n_drive;
            r_rising  <= n_rising;
            r_falling <= n_falling;
            r_supply  <= n_supply;
            r_updated <= n_updated;
            if (i_cmd.err_load) begin
                r_error <= w_err_sat;
            end
            if (cfg.valid) begin
                r_threshold <= cfg.plausible_threshold;
            end
            if (i_cmd.publish) begin
                r_out_valid <= 1'b1;
            end else if (res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_quo <= {r_falling, SCALE_SHIFT'(0)};
            r_rem <= '0;
            r_div <= r_rising;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
            r_rem <= w_ge ? w_rem_diff[ADC_BITS-1:0] : w_rem_sh[ADC_BITS-1:0];
        end
        if (i_cmd.publish) begin
            r_out_sector    <= r_sector;
            r_out_drive     <= r_drive;
            r_out_updated   <= r_updated;
            r_out_rising    <= r_rising;
            r_out_falling   <= r_falling;
            r_out_supply    <= r_supply;
            r_out_error     <= r_error;
            r_out_plausible <= w_plausible;
        end
    end

    assign res.valid           = r_out_valid;
    assign res.sector          = r_out_sector;
    assign res.phase_a_mode    = r_out_drive.a;
    assign res.phase_b_mode    = r_out_drive.b;
    assign res.phase_c_mode    = r_out_drive.c;
    assign res.drive_updated   = r_out_updated;
    assign res.bemf_rising     = r_out_rising;
    assign res.bemf_falling    = r_out_falling;
    assign res.supply_voltage  = r_out_supply;
    assign res.timing_error    = r_out_error;
    assign res.error_plausible = r_out_plausible;

    `SSCS_ASSERT(a_sector_range, r_sector < NUM_SECTORS, "sector left the six-step range")
    `SSCS_ASSERT(a_modes_legal, r_drive.a <= MODE_FLOAT && r_drive.b <= MODE_FLOAT && r_drive.c <= MODE_FLOAT, "illegal phase drive mode")
    `SSCS_ASSERT_NEXT(a_publish_sets_valid, i_cmd.publish, r_out_valid, "published result not presented")

endmodule
`default_nettype wire

>>> rtl/core/six_step_commutation_sequencer_unit.sv
// six-step commutation sequencer top level
//
// i_cmd carries one command per transaction: advance (func 0) or align
// (func 1), the motor running flag and the latest adc sample. every command
// produces exactly one transaction on o_res with the sector reached, the
// three phase drive modes and the back-emf, supply and timing error values.
// i_cfg writes the plausibility threshold; write it only while idle.
// a command is taken only in idle; its result is then registered in the
// output register on publish. an advance into sector five while running
// first runs the restoring divider, one quotient bit per cycle over
// ADC_BITS+6 bits, and saturates the timing error before publish. no new
// command is taken until the previous one has been published.
// the output register holds a finished result while the next command is
// taken; if o_res stalls, the following result waits in the controller and
// i_cmd stays not ready until the register frees.
// reset: sector 0, all phases floating, averages, supply and error cleared,
// threshold 1016, no result pending.
`default_nettype none
module six_step_commutation_sequencer_unit
    import sscs_pkg::*;
#(
    parameter int ADC_BITS = 10
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    sscs_cmd_if.sink   i_cmd,
    sscs_cfg_if.sink   i_cfg,
    sscs_res_if.source o_res
);
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_cmd_ready;

    assign i_cmd.ready = w_cmd_ready;

    sscs_ctrl #(
        .ADC_BITS (ADC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd.valid),
        .o_cmd_ready (w_cmd_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    sscs_dp #(
        .ADC_BITS (ADC_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_func          (i_cmd.func),
        .i_motor_running (i_cmd.motor_running),
        .i_adc_sample    (i_cmd.adc_sample),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .cfg             (i_cfg),
        .res             (o_res)
    );

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// testbench for the six-step commutation sequencer: random commands, self-checking predictor
`timescale 1ns / 1ps

module tb_top
    import sscs_pkg::*;
;

    localparam int ADC_BITS       = 10;
    localparam int ADC_MAX        = (1 << ADC_BITS) - 1;
    localparam int SETTLE_CYCLES  = 25;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic [MODE_W-1:0]   mode_a;
        logic [MODE_W-1:0]   mode_b;
        logic [MODE_W-1:0]   mode_c;
        logic                updated;
        logic [ADC_BITS-1:0] rising;
        logic [ADC_BITS-1:0] falling;
        logic [ADC_BITS-1:0] supply;
        logic [ERR_W-1:0]    err;
        logic                plausible;
    } t_sector_result;

    logic clk = 1'b0;
    logic rst_n;

    sscs_cmd_if #(.ADC_BITS(ADC_BITS)) cmd_if ();
    sscs_cfg_if                        cfg_if ();
    sscs_res_if #(.ADC_BITS(ADC_BITS)) res_if ();

    six_step_commutation_sequencer_unit #(.ADC_BITS(ADC_BITS)) u_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_cmd  (cmd_if),
        .i_cfg  (cfg_if),
        .o_res  (res_if)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor state
    logic [SECTOR_W-1:0] m_sector;
    logic [ADC_BITS-1:0] m_rising;
    logic [ADC_BITS-1:0] m_falling;
    logic [ADC_BITS-1:0] m_supply;
    logic [ERR_W-1:0]    m_err;
    logic [MODE_W-1:0]   m_mode [3];
    logic [THR_W-1:0]    m_threshold;

    t_sector_result pending_results [$];

    bit gaps_on;
    int cmd_count, result_count, mismatch_count;
    int align_count, stopped_count, zero_div_count, saturated_count, thr_writes;
    int idle_cycles;

    function automatic void run_sector_actions(input int sec, input logic [ADC_BITS-1:0] s);
        int pwm_phase, low_phase, q;
        // high side steps every two sectors, low side lags it by one sector
        pwm_phase = sec / 2;
        low_phase = ((sec + 1) / 2 + 1) % 3;
        for (int p = 0; p < 3; p++) begin
            if (p == pwm_phase) m_mode[p] = MODE_PWM;
            else if (p == low_phase) m_mode[p] = MODE_LOW;
            else m_mode[p] = MODE_FLOAT;
        end
        case (sec)
            SECTOR_RISING:  m_rising = ADC_BITS'((int'(m_rising) + int'(s)) >> 1);
            SECTOR_SUPPLY:  m_supply = s;
            SECTOR_FALLING: m_falling = ADC_BITS'((int'(m_falling) + int'(s)) >> 1);
            SECTOR_ERROR: begin
                if (m_rising == '0) begin
                    m_err = ERR_MAX;
                    zero_div_count++;
                end else begin
                    q = (int'(m_falling) << SCALE_SHIFT) / int'(m_rising)
                        - (1 << SCALE_SHIFT);
                    if (q > int'(ERR_MAX)) begin
                        q = int'(ERR_MAX);
                        saturated_count++;
                    end
                    m_err = q[ERR_W-1:0];
                end
            end
            default: ;
        endcase
    endfunction

    function automatic t_sector_result next_commutation(input logic f, input logic run,
                                                        input logic [ADC_BITS-1:0] s);
        t_sector_result r;
        r.updated = 1'b1;
        if (f == FUNC_ALIGN) begin
            m_sector = SECTOR_RISING;
            run_sector_actions(0, s);
            align_count++;
        end else begin
            m_sector = SECTOR_W'((int'(m_sector) + 1) % int'(NUM_SECTORS));
            if (run) begin
                run_sector_actions(int'(m_sector), s);
            end else begin
                m_rising  = '0;
                m_falling = '0;
                m_supply  = '0;
                r.updated = 1'b0;
                stopped_count++;
            end
        end
        r.sector    = m_sector;
        r.mode_a    = m_mode[0];
        r.mode_b    = m_mode[1];
        r.mode_c    = m_mode[2];
        r.rising    = m_rising;
        r.falling   = m_falling;
        r.supply    = m_supply;
        r.err       = m_err;
        r.plausible = (int'(m_rising) + int'(m_falling)) > int'(m_threshold);
        return r;
    endfunction

    task automatic report_fault(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%0t mismatch: %s", $realtime, msg);
    endtask

    function automatic string field_diff(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
        if (want !== got) return $sformatf(" %s exp %0d got %0d", name, want, got);
        return "";
    endfunction

    task automatic send_command(input logic f, input logic run, input logic [ADC_BITS-1:0] s);
        int gap;
        gap = gaps_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_if.valid         <= 1'b1;
        cmd_if.func          <= f;
        cmd_if.motor_running <= run;
        cmd_if.adc_sample    <= s;
        @(posedge clk);
        while (!cmd_if.ready) @(posedge clk);
        pending_results.push_back(next_commutation(f, run, s));
        cmd_count++;
    endtask

    task automatic drain_results();
        cmd_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic settle();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] v);
        cfg_if.valid               <= 1'b1;
        cfg_if.plausible_threshold <= v;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        cfg_if.valid <= 1'b0;
        m_threshold = v;
        thr_writes++;
    endtask

    function automatic logic [ADC_BITS-1:0] pick_sample(input int scale);
        case (scale)
            1:       return ADC_BITS'($urandom_range(0, 15));
            2:       return ADC_BITS'($urandom_range(ADC_MAX - 15, ADC_MAX));
            3:       return ADC_BITS'($urandom_range(0, 1) ? ADC_MAX : 0);
            default: return ADC_BITS'($urandom_range(0, ADC_MAX));
        endcase
    endfunction

    task automatic test_directed_sectors();
        gaps_on = 1'b1;
        // advance while stopped right after reset
        send_command(FUNC_ADVANCE, 1'b0, '0);
        // advance to the error sector with zero rising average: zero divisor there
        send_command(FUNC_ADVANCE, 1'b1, ADC_BITS'(ADC_MAX));
        send_command(FUNC_ADVANCE, 1'b1, ADC_BITS'(ADC_MAX));
        send_command(FUNC_ADVANCE, 1'b1, '0);
        send_command(FUNC_ADVANCE, 1'b1, ADC_BITS'(ADC_MAX));
        // align, then small rising and large falling average
        send_command(FUNC_ALIGN, 1'b1, ADC_BITS'(2));
        send_command(FUNC_ADVANCE, 1'b1, '0);
        send_command(FUNC_ADVANCE, 1'b1, ADC_BITS'(ADC_MAX));
        send_command(FUNC_ADVANCE, 1'b1, ADC_BITS'(ADC_MAX));
        send_command(FUNC_ADVANCE, 1'b1, '0);
        send_command(FUNC_ADVANCE, 1'b1, '0);
        // second turn pushes the error past the positive limit
        send_command(FUNC_ADVANCE, 1'b1, ADC_BITS'(1));
        send_command(FUNC_ADVANCE, 1'b1, '0);
        send_command(FUNC_ADVANCE, 1'b1, '0);
        send_command(FUNC_ADVANCE, 1'b1, ADC_BITS'(ADC_MAX));
        send_command(FUNC_ADVANCE, 1'b1, '0);
        send_command(FUNC_ADVANCE, 1'b1, ADC_BITS'(ADC_MAX));
        // align while stopped, then a clearing advance
        send_command(FUNC_ALIGN, 1'b0, ADC_BITS'(ADC_MAX));
        send_command(FUNC_ADVANCE, 1'b0, ADC_BITS'(ADC_MAX));
        settle();
    endtask

    task automatic test_threshold_sweep();
        logic [THR_W-1:0] thr_list [6];
        thr_list = '{11'd0, 11'd2047, 11'd1, 11'd2046, 11'd0, PLAUS_RESET};
        thr_list[4] = THR_W'($urandom_range(0, 2047));
        for (int i = 0; i < 6; i++) begin
            write_threshold(thr_list[i]);
            gaps_on = (i % 2 == 0);
            send_command(FUNC_ALIGN, 1'b1, pick_sample(i % 4));
            repeat (11) send_command(FUNC_ADVANCE, 1'b1, pick_sample(i % 4));
            settle();
        end
    endtask

    task automatic test_drain_pressure();
        int n;
        gaps_on = 1'b0;
        for (int i = 0; i < 10; i++) begin
            n = $urandom_range(1, 4);
            repeat (n) send_command(1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0,
                                    pick_sample(0));
            drain_results();
        end
        settle();
    endtask

    task automatic test_random_sequences(input int total);
        int sent, n, scale;
        sent = 0;
        for (int chunk = 0; chunk < 5; chunk++) begin
            if (chunk == 1) write_threshold(11'd0);
            else if (chunk == 3) write_threshold(11'd2047);
            else write_threshold(THR_W'($urandom_range(0, 2047)));
            while (sent < (total * (chunk + 1)) / 5) begin
                gaps_on = ($urandom_range(0, 3) != 0);
                scale = $urandom_range(0, 5);
                if ($urandom_range(0, 4) != 0) begin
                    // well-formed run: optional align then running advances
                    if ($urandom_range(0, 3) != 0) begin
                        send_command(FUNC_ALIGN, 1'($urandom_range(0, 1)),
                                     pick_sample(scale));
                        sent++;
                    end
                    n = $urandom_range(6, 18);
                    repeat (n) send_command(FUNC_ADVANCE, 1'b1, pick_sample(scale));
                end else begin
                    n = $urandom_range(1, 6);
                    repeat (n) send_command(1'($urandom_range(0, 1)),
                                            1'($urandom_range(0, 1)),
                                            pick_sample(scale));
                end
                sent += n;
            end
            settle();
        end
    endtask

    // result checker
    initial begin : result_monitor
        t_sector_result got, want;
        int stall;
        string bad;
        res_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            stall = gaps_on ? $urandom_range(0, 9) : 0;
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            @(posedge clk);
            while (!res_if.valid) @(posedge clk);
            got.sector    = res_if.sector;
            got.mode_a    = res_if.phase_a_mode;
            got.mode_b    = res_if.phase_b_mode;
            got.mode_c    = res_if.phase_c_mode;
            got.updated   = res_if.drive_updated;
            got.rising    = res_if.bemf_rising;
            got.falling   = res_if.bemf_falling;
            got.supply    = res_if.supply_voltage;
            got.err       = res_if.timing_error;
            got.plausible = res_if.error_plausible;
            result_count++;
            if (pending_results.size() == 0) begin
                report_fault($sformatf("result %0d with nothing expected", result_count));
            end else begin
                want = pending_results.pop_front();
                bad = {field_diff("sector", want.sector, got.sector),
                       field_diff("phase_a", want.mode_a, got.mode_a),
                       field_diff("phase_b", want.mode_b, got.mode_b),
                       field_diff("phase_c", want.mode_c, got.mode_c),
                       field_diff("updated", want.updated, got.updated),
                       field_diff("rising", want.rising, got.rising),
                       field_diff("falling", want.falling, got.falling),
                       field_diff("supply", want.supply, got.supply),
                       field_diff("error", want.err, got.err),
                       field_diff("plausible", want.plausible, got.plausible)};
                if (bad != "") report_fault($sformatf("result %0d:%s", result_count, bad));
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("[six_step_commutation_sequencer_unit] ERROR");
        $finish;
    end

    initial begin : stimulus
        rst_n                      = 1'b0;
        cmd_if.valid               = 1'b0;
        cmd_if.func                = FUNC_ADVANCE;
        cmd_if.motor_running       = 1'b0;
        cmd_if.adc_sample          = '0;
        cfg_if.valid               = 1'b0;
        cfg_if.plausible_threshold = '0;
        gaps_on                    = 1'b1;
        m_sector    = SECTOR_RISING;
        m_rising    = '0;
        m_falling   = '0;
        m_supply    = '0;
        m_err       = '0;
        m_mode      = '{MODE_FLOAT, MODE_FLOAT, MODE_FLOAT};
        m_threshold = PLAUS_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_sectors();
        test_threshold_sweep();
        test_drain_pressure();
        test_random_sequences(1430);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("run: %0d commands (%0d aligns, %0d stopped advances), %0d results checked",
                 cmd_count, align_count, stopped_count, result_count);
        $display("run: %0d threshold writes, %0d zero-divisor and %0d saturated error cases",
                 thr_writes, zero_div_count, saturated_count);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("[six_step_commutation_sequencer_unit] OK");
        end else begin
            $display("%0d mismatches, %0d results outstanding", mismatch_count,
                     pending_results.size());
            $display("[six_step_commutation_sequencer_unit] ERROR");
        end
        $finish;
    end

endmodule
